@@ design/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg: shared constants, types and helpers
// Sizes, field widths, channel payload structs and code names used across
// the strip cluster counter.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  localparam int CHANNELS       = 384;
  localparam int DETECTORS      = 3;
  localparam int MAX_THRESHOLDS = 16;
  localparam int CHIP_CHANNELS  = 64;

  localparam int DET_W     = 3;
  localparam int CHAN_W    = 10;
  localparam int SAMPLE_W  = 16;
  localparam int BASE_W    = 20;
  localparam int SIGMA_W   = 16;
  localparam int FRAME_W   = 10;
  localparam int TOTAL_W   = 32;
  localparam int TIDX_W    = 4;
  localparam int START_W   = 12;
  localparam int STEP_W    = 8;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam int DEV_W  = BASE_W + 4;
  localparam int THR_W  = $clog2((2 ** START_W - 1) + (MAX_THRESHOLDS - 1) * (2 ** STEP_W - 1) + 1);
  localparam int PROD_W = THR_W + SIGMA_W;
  localparam int KI_W   = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;

  localparam int POS_W     = $clog2(CHANNELS + 1);
  localparam int CH_IDX_W  = $clog2(CHANNELS);
  localparam int OFF_W     = $clog2(CHIP_CHANNELS);
  localparam int CAL_DEPTH = DETECTORS * CHANNELS;
  localparam int CAL_AW    = $clog2(CAL_DEPTH);
  localparam int TOT_DEPTH = DETECTORS * MAX_THRESHOLDS;
  localparam int TOT_AW    = (TOT_DEPTH > 1) ? $clog2(TOT_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FUNC_CAL    = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_START = 2'd0,
    REG_THR_STEP  = 2'd1,
    REG_THR_COUNT = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [STEP_W-1:0]  step;
    logic [CNT_W-1:0]   nthr;
  } scc_cfg_t;

  typedef struct packed {
    logic [BASE_W-1:0]  baseline;
    logic [SIGMA_W-1:0] sigma;
    logic               bad;
  } scc_cal_t;

  typedef struct packed {
    logic [DET_W-1:0]   det;
    logic [DEV_W-1:0]   dev;
    logic [SIGMA_W-1:0] sigma;
    logic               usable;
    logic               counted;
    logic               last;
  } scc_item_t;

  typedef struct packed {
    logic                                   valid;
    logic [DET_W-1:0]                       det;
    logic [MAX_THRESHOLDS-1:0][FRAME_W-1:0] counts;
  } scc_load_t;

  function automatic logic [CNT_W-1:0] active_thresholds(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = cnt;
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(MAX_THRESHOLDS)) n = CNT_W'(MAX_THRESHOLDS);
    return n;
  endfunction

endpackage

`default_nettype wire

@@ design/scc_ifs.sv @@
// ----------------------------------------------------------------------------
// scc_ifs: valid/ready channels of the strip cluster counter
// Input channel carries calibration writes and raw samples; output channel
// carries per-threshold cluster reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_in_if import scc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [DET_W-1:0]    detector;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample;
  logic [BASE_W-1:0]   cal_baseline;
  logic [SIGMA_W-1:0]  cal_sigma;
  logic                cal_bad;
  logic                last_sample;

  modport source (
    output valid, func, detector, channel, sample, cal_baseline, cal_sigma, cal_bad,
    output last_sample,
    input  ready
  );
  modport sink (
    input  valid, func, detector, channel, sample, cal_baseline, cal_sigma, cal_bad,
    input  last_sample,
    output ready
  );
endinterface

interface scc_out_if import scc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DET_W-1:0]   out_detector;
  logic [TIDX_W-1:0]  threshold_index;
  logic [FRAME_W-1:0] frame_clusters;
  logic [TOTAL_W-1:0] total_clusters;
  logic               last_result;

  modport source (
    output valid, out_detector, threshold_index, frame_clusters, total_clusters,
    output last_result,
    input  ready
  );
  modport sink (
    input  valid, out_detector, threshold_index, frame_clusters, total_clusters,
    input  last_result,
    output ready
  );
endinterface

`default_nettype wire

@@ design/strip_cluster_count_vs_threshold.sv @@
// ----------------------------------------------------------------------------
// strip_cluster_count_vs_threshold: strip cluster counter over a threshold sweep
// Calibration lookup, per-threshold run counting and saturating totals,
// reported per threshold at each frame end.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while the queue has room, one result
//   word per cycle while the output is ready. A sample is counted after the
//   calibration read register, the queue and the lane product register.
// A frame end waits in the queue while the previous frame's report still
//   runs through the totals memory.
// Reset clears control, counters and totals at once; calibration is not cleared.
`default_nettype none

module strip_cluster_count_vs_threshold import scc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  scc_in_if.sink               item,
  scc_out_if.source            result
);

  logic [START_W-1:0] thr_start;
  logic [STEP_W-1:0]  thr_step;
  logic [CNT_W-1:0]   thr_count;
  scc_cfg_t           cfg;

  logic             push;
  scc_item_t        push_item;
  scc_item_t        head;
  logic             head_valid;
  logic [LVL_W-1:0] level;
  logic             pop;
  scc_load_t        load;
  logic             rep_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_start <= START_W'(16);
      thr_step  <= STEP_W'(16);
      thr_count <= CNT_W'(15);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THR_START: thr_start <= cfg_data[START_W-1:0];
        REG_THR_STEP:  thr_step  <= cfg_data[STEP_W-1:0];
        REG_THR_COUNT: thr_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.start = thr_start;
    cfg.step  = thr_step;
    cfg.nthr  = active_thresholds(thr_count);
  end

  scc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .level     (level),
    .push      (push),
    .push_item (push_item)
  );

  scc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (level)
  );

  scc_lanes u_lanes (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .rep_busy   (rep_busy),
    .pop        (pop),
    .load       (load)
  );

  scc_report u_report (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .load     (load),
    .rep_busy (rep_busy),
    .result   (result)
  );

endmodule

`default_nettype wire

@@ design/scc_front.sv @@
// ----------------------------------------------------------------------------
// scc_front: input decode and calibration lookup
// Stores calibration words, tracks frame position, fetches the calibration
// of each sample and forms its deviation and mask before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_front import scc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  scc_in_if.sink        item,
  input  logic [LVL_W-1:0] level,
  output logic          push,
  output scc_item_t     push_item
);

  localparam bit          CHIP_ALIGNED = (CHANNELS % CHIP_CHANNELS) == 0;
  localparam logic [DET_W:0]  DET_LIMIT = (DET_W + 1)'(DETECTORS);
  localparam logic [CHAN_W:0] CH_LIMIT  = (CHAN_W + 1)'(CHANNELS);

  scc_cal_t cal_mem [CAL_DEPTH];
  scc_cal_t cal_rd;

  logic [POS_W-1:0] pos;
  logic [OFF_W-1:0] off;

  logic                a_valid;
  logic [DET_W-1:0]    a_det;
  logic [SAMPLE_W-1:0] a_sample;
  logic                a_last;
  logic                a_counted;
  logic                a_border;

  logic              accept;
  logic              det_ok;
  logic              is_sample;
  logic              is_cal;
  logic              counted;
  logic              border;
  logic [CAL_AW-1:0] wr_addr;
  logic [CAL_AW-1:0] rd_addr;
  logic [BASE_W-1:0] s16;
  logic [BASE_W-1:0] adiff;

  assign item.ready = ((LVL_W + 1)'(level) + (LVL_W + 1)'(a_valid)) < (LVL_W + 1)'(QUEUE_DEPTH);

  assign accept    = item.valid && item.ready;
  assign det_ok    = {1'b0, item.detector} < DET_LIMIT;
  assign is_sample = accept && det_ok && (item.func == FUNC_SAMPLE);
  assign is_cal    = accept && det_ok && (item.func == FUNC_CAL) &&
                     ({1'b0, item.channel} < CH_LIMIT);
  assign counted   = pos < POS_W'(CHANNELS);

  always_comb begin
    if (CHIP_ALIGNED) begin
      border = (off == '0) || (off == OFF_W'(CHIP_CHANNELS - 1));
    end else begin
      border = (pos == '0) || (pos == POS_W'(CHANNELS - 1));
    end
  end

  assign wr_addr = CAL_AW'(item.detector) * CAL_AW'(CHANNELS) + CAL_AW'(item.channel);
  assign rd_addr = CAL_AW'(item.detector) * CAL_AW'(CHANNELS) + CAL_AW'(pos[CH_IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (is_cal) begin
      cal_mem[wr_addr] <= '{baseline: item.cal_baseline, sigma: item.cal_sigma,
                            bad: item.cal_bad};
    end
    if (is_sample && counted) begin
      cal_rd <= cal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      off     <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= is_sample && (counted || item.last_sample);
      if (is_sample) begin
        if (item.last_sample) begin
          pos <= '0;
          off <= '0;
        end else if (counted) begin
          pos <= pos + 1'b1;
          off <= (off == OFF_W'(CHIP_CHANNELS - 1)) ? '0 : off + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      a_det     <= item.detector;
      a_sample  <= item.sample;
      a_last    <= item.last_sample;
      a_counted <= counted;
      a_border  <= border;
    end
  end

  assign s16   = {a_sample, 4'b0000};
  assign adiff = (s16 >= cal_rd.baseline) ? s16 - cal_rd.baseline : cal_rd.baseline - s16;

  assign push = a_valid;

  always_comb begin
    push_item.det     = a_det;
    push_item.dev     = {adiff, 4'b0000};
    push_item.sigma   = cal_rd.sigma;
    push_item.usable  = !cal_rd.bad && !a_border && (cal_rd.sigma != '0);
    push_item.counted = a_counted;
    push_item.last    = a_last;
  end

endmodule

`default_nettype wire

@@ design/scc_queue.sv @@
// ----------------------------------------------------------------------------
// scc_queue: short item queue between front and threshold lanes
// Registered circular buffer; lets the front and the lanes stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_queue import scc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scc_item_t        push_item,
  input  logic             pop,
  output scc_item_t        head,
  output logic             head_valid,
  output logic [LVL_W-1:0] level
);

  scc_item_t        slots [QUEUE_DEPTH];
  logic [QP_W-1:0]  wptr;
  logic [QP_W-1:0]  rptr;

  function automatic logic [QP_W-1:0] bump(input logic [QP_W-1:0] p);
    return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = slots[rptr];
  assign head_valid = level != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) wptr <= bump(wptr);
      if (pop)  rptr <= bump(rptr);
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level != LVL_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ design/scc_lanes.sv @@
// ----------------------------------------------------------------------------
// scc_lanes: per-threshold hit test and run counting
// One lane per threshold: noise product, hit compare, in-run flag and frame
// cluster count. Hands the frame counts to the reporter at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_lanes import scc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  scc_cfg_t  cfg,
  input  scc_item_t head,
  input  logic      head_valid,
  input  logic      rep_busy,
  output logic      pop,
  output scc_load_t load
);

  logic [THR_W-1:0]  thr      [MAX_THRESHOLDS];
  logic [MAX_THRESHOLDS-1:0] thr_zero;
  logic [PROD_W-1:0] prod     [MAX_THRESHOLDS];

  logic      c_valid;
  scc_item_t c_item;

  logic [MAX_THRESHOLDS-1:0]              flags;
  logic [MAX_THRESHOLDS-1:0][FRAME_W-1:0] counts;
  logic [MAX_THRESHOLDS-1:0]              flags_next;
  logic [MAX_THRESHOLDS-1:0][FRAME_W-1:0] counts_next;
  logic [MAX_THRESHOLDS-1:0]              hit;
  logic                                   frame_end;

  assign frame_end = c_valid && c_item.last;
  assign pop = head_valid && (!head.last || (!rep_busy && !frame_end));

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_THRESHOLDS; k++) begin
      thr[k]      <= THR_W'(cfg.start) + THR_W'(k) * THR_W'(cfg.step);
      thr_zero[k] <= (cfg.start == '0) && ((k == 0) || (cfg.step == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      c_item <= head;
      for (int k = 0; k < MAX_THRESHOLDS; k++) begin
        prod[k] <= PROD_W'(thr[k]) * PROD_W'(head.sigma);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_THRESHOLDS; k++) begin
      hit[k] = c_item.usable ? (PROD_W'(c_item.dev) >= prod[k]) : thr_zero[k];
      flags_next[k]  = flags[k];
      counts_next[k] = counts[k];
      if (c_valid && c_item.counted && (CNT_W'(k) < cfg.nthr)) begin
        flags_next[k] = hit[k];
        if (hit[k] && !flags[k]) counts_next[k] = counts[k] + 1'b1;
      end
    end
  end

  always_comb begin
    load.valid  = frame_end;
    load.det    = c_item.det;
    load.counts = counts_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      flags   <= '0;
      counts  <= '0;
    end else begin
      c_valid <= pop;
      if (frame_end) begin
        flags  <= '0;
        counts <= '0;
      end else begin
        flags  <= flags_next;
        counts <= counts_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/scc_report.sv @@
// ----------------------------------------------------------------------------
// scc_report: frame-end reporter and running totals
// Walks the thresholds of a finished frame, adds each count into the
// saturating total of its detector and presents one report per threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_report import scc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  scc_cfg_t  cfg,
  input  scc_load_t load,
  output logic      rep_busy,
  scc_out_if.source result
);

  logic [TOTAL_W-1:0]   tot_mem [TOT_DEPTH];
  logic [TOT_DEPTH-1:0] tot_ok;
  logic [TOTAL_W-1:0]   tot_rd;
  logic                 tot_rd_ok;

  logic                                   busy;
  logic [DET_W-1:0]                       rdet;
  logic [MAX_THRESHOLDS-1:0][FRAME_W-1:0] rcounts;
  logic [CNT_W-1:0]                       nrep;
  logic [CNT_W-1:0]                       iss_k;

  logic              p1_valid;
  logic              p1_last;
  logic [TIDX_W-1:0] p1_k;
  logic [TOT_AW-1:0] p1_addr;

  logic               out_valid;
  logic [DET_W-1:0]   out_det;
  logic [TIDX_W-1:0]  out_k;
  logic [FRAME_W-1:0] out_frame;
  logic [TOTAL_W-1:0] out_total;
  logic               out_last;

  logic               issue;
  logic               fire;
  logic [TOT_AW-1:0]  iss_addr;
  logic [FRAME_W-1:0] cur_count;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sum_sat;

  assign rep_busy = busy;

  assign fire     = p1_valid && (!out_valid || result.ready);
  assign issue    = busy && (iss_k < nrep) && (!p1_valid || fire);
  assign iss_addr = TOT_AW'(rdet) * TOT_AW'(MAX_THRESHOLDS) + TOT_AW'(iss_k);

  assign cur_count = rcounts[p1_k[KI_W-1:0]];
  assign sum       = {1'b0, (tot_rd_ok ? tot_rd : '0)} + (TOTAL_W + 1)'(cur_count);
  assign sum_sat   = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (issue) begin
      tot_rd    <= tot_mem[iss_addr];
      tot_rd_ok <= tot_ok[iss_addr];
    end
    if (fire) begin
      tot_mem[p1_addr] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      nrep      <= '0;
      iss_k     <= '0;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
      tot_ok    <= '0;
    end else begin
      if (load.valid) begin
        busy  <= 1'b1;
        nrep  <= cfg.nthr;
        iss_k <= '0;
      end else begin
        if (fire && p1_last) busy <= 1'b0;
        if (issue) iss_k <= iss_k + 1'b1;
      end
      if (issue) begin
        p1_valid <= 1'b1;
      end else if (fire) begin
        p1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid       <= 1'b1;
        tot_ok[p1_addr] <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      rdet    <= load.det;
      rcounts <= load.counts;
    end
    if (issue) begin
      p1_k    <= TIDX_W'(iss_k);
      p1_last <= iss_k == (nrep - 1'b1);
      p1_addr <= iss_addr;
    end
    if (fire) begin
      out_det   <= rdet;
      out_k     <= p1_k;
      out_frame <= cur_count;
      out_total <= sum_sat;
      out_last  <= p1_last;
    end
  end

  assign result.valid           = out_valid;
  assign result.out_detector    = out_det;
  assign result.threshold_index = out_k;
  assign result.frame_clusters  = out_frame;
  assign result.total_clusters  = out_total;
  assign result.last_result     = out_last;

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load.valid |-> !busy)
    else $error("frame counts handed over while a report runs");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (fire && p1_last) |=> !busy)
    else $error("reporter still busy after last threshold");

  a_pipe_in_report: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> busy)
    else $error("total lookup in flight outside a report");

endmodule

`default_nettype wire

@@ sim/cluster_report_checker.sv @@
// ----------------------------------------------------------------------------
// cluster_report_checker: cluster count predictor and report comparison
// Watches the threshold register port and both channels of the strip cluster
// counter. It keeps its own copy of the calibration tables, the per-threshold
// run state and the saturating totals. It queues the reports that each
// accepted frame end should produce, then compares every accepted report
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module cluster_report_checker import scc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  scc_in_if                    item,
  scc_out_if                   result,
  output int                   errors,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DET_W-1:0]   det;
    logic [TIDX_W-1:0]  tidx;
    logic [FRAME_W-1:0] clusters;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } report_t;

  logic [BASE_W-1:0]  cal_base_tbl  [CAL_DEPTH];
  logic [SIGMA_W-1:0] cal_sigma_tbl [CAL_DEPTH];
  logic               cal_bad_tbl   [CAL_DEPTH];

  logic [MAX_THRESHOLDS-1:0] in_cluster;
  logic [FRAME_W-1:0]        clusters_now [MAX_THRESHOLDS];
  logic [TOTAL_W-1:0]        clusters_sum [TOT_DEPTH];
  int                        next_chan;

  logic [START_W-1:0] thr_start;
  logic [STEP_W-1:0]  thr_step;
  logic [CNT_W-1:0]   thr_count;

  report_t reports_due [$];

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_report();
    report_t r;
    if (reports_due.size() == 0) begin
      $error("report with nothing due: detector %0d, threshold %0d",
             result.out_detector, result.threshold_index);
      errors++;
      return;
    end
    r = reports_due.pop_front();
    compare_field("out_detector", r.det, result.out_detector);
    compare_field("threshold_index", r.tidx, result.threshold_index);
    compare_field("frame_clusters", r.clusters, result.frame_clusters);
    compare_field("total_clusters", r.total, result.total_clusters);
    compare_field("last_result", r.last, result.last_result);
  endtask

  task automatic take_word();
    int          a, t, n, off;
    bit          usable, hit;
    logic [63:0] s16, base, dev, thr;
    logic [32:0] sum;
    report_t     r;
    if (item.detector >= DETECTORS) return;
    if (item.func == FUNC_CAL) begin
      if (item.channel < CHANNELS) begin
        a = item.detector * CHANNELS + item.channel;
        cal_base_tbl[a]  = item.cal_baseline;
        cal_sigma_tbl[a] = item.cal_sigma;
        cal_bad_tbl[a]   = item.cal_bad;
      end
      return;
    end
    n = (thr_count == 0) ? 1 : ((thr_count > MAX_THRESHOLDS) ? MAX_THRESHOLDS : thr_count);
    if (next_chan < CHANNELS) begin
      a   = item.detector * CHANNELS + next_chan;
      off = next_chan % CHIP_CHANNELS;
      if ((CHANNELS % CHIP_CHANNELS) != 0)
        usable = (next_chan != 0) && (next_chan != CHANNELS - 1);
      else
        usable = (off != 0) && (off != CHIP_CHANNELS - 1);
      usable = usable && !cal_bad_tbl[a] && (cal_sigma_tbl[a] != 0);
      s16  = 64'(item.sample) << 4;
      base = 64'(cal_base_tbl[a]);
      dev  = ((s16 >= base) ? s16 - base : base - s16) << 4;
      for (int k = 0; k < n; k++) begin
        thr = 64'(thr_start) + 64'(k) * 64'(thr_step);
        hit = usable ? (dev >= thr * 64'(cal_sigma_tbl[a])) : (thr == 0);
        if (hit && !in_cluster[k]) begin
          in_cluster[k]   = 1'b1;
          clusters_now[k] = clusters_now[k] + 1'b1;
        end else if (!hit) begin
          in_cluster[k] = 1'b0;
        end
      end
      next_chan++;
    end
    if (item.last_sample) begin
      for (int k = 0; k < n; k++) begin
        t   = item.detector * MAX_THRESHOLDS + k;
        sum = {1'b0, clusters_sum[t]} + 33'(clusters_now[k]);
        clusters_sum[t] = sum[32] ? '1 : sum[TOTAL_W-1:0];
        r.det      = item.detector;
        r.tidx     = TIDX_W'(k);
        r.clusters = clusters_now[k];
        r.total    = clusters_sum[t];
        r.last     = (k == n - 1);
        reports_due = {reports_due, r};
      end
      in_cluster = '0;
      foreach (clusters_now[k]) clusters_now[k] = '0;
      next_chan = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_cluster = '0;
      foreach (clusters_now[k]) clusters_now[k] = '0;
      foreach (clusters_sum[t]) clusters_sum[t] = '0;
      next_chan = 0;
      thr_start = START_W'(16);
      thr_step  = STEP_W'(16);
      thr_count = CNT_W'(15);
      reports_due.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_e'(cfg_index))
          REG_THR_START: thr_start = cfg_data[START_W-1:0];
          REG_THR_STEP:  thr_step  = cfg_data[STEP_W-1:0];
          REG_THR_COUNT: thr_count = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) check_report();
      if (item.valid && item.ready) take_word();
      outstanding <= reports_due.size();
    end
  end

endmodule

@@ sim/strip_cluster_count_vs_threshold_tb.sv @@
// ----------------------------------------------------------------------------
// strip_cluster_count_vs_threshold_tb: threshold sweep cluster counter bench
// Loads calibration for the leading channels of every detector, runs directed
// frames covering masked, zero-sigma, bad and out-of-range cases, then random
// short frames across several threshold settings, with random gaps on both
// channels outside the last third. A checker predicts and compares the reports.
// ----------------------------------------------------------------------------
module strip_cluster_count_vs_threshold_tb import scc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    func_e               func;
    logic [DET_W-1:0]    det;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] sample;
    logic [BASE_W-1:0]   base;
    logic [SIGMA_W-1:0]  sigma;
    logic                bad;
    logic                last;
  } strip_word_t;

  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 20;
  localparam int RANDOM_WORDS = PHASES * PHASE_WORDS;
  localparam int CAL_SPAN     = 16;
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT  = 2000;

  localparam logic [CFG_DAT_W-1:0] START_SET [PHASES] = '{
    12'd0, 12'd4095, 12'd0, 12'd8, 12'd32, 12'd20, 12'd16, 12'd4};
  localparam logic [CFG_DAT_W-1:0] STEP_SET [PHASES] = '{
    12'd1, 12'd255, 12'hF00, 12'd4, 12'd255, 12'd12, 12'd16, 12'd2};
  localparam logic [CFG_DAT_W-1:0] COUNT_SET [PHASES] = '{
    12'd16, 12'd16, 12'd0, 12'd31, 12'd1, 12'd8, 12'd15, 12'd12};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int fail_count;
  int reports_pending;
  int quiet_cycles = 0;
  int tx_idle_pct  = 36;
  int rx_idle_pct  = 55;
  int random_words = 0;

  scc_in_if  in_ch ();
  scc_out_if res_ch ();

  strip_cluster_count_vs_threshold i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (in_ch),
    .result    (res_ch)
  );

  cluster_report_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (in_ch),
    .result      (res_ch),
    .errors      (fail_count),
    .outstanding (reports_pending)
  );

  always #2 clk = ~clk;

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic strip_word_t calib_word(input logic [DET_W-1:0] det,
                                             input logic [CHAN_W-1:0] chan,
                                             input logic [BASE_W-1:0] base,
                                             input logic [SIGMA_W-1:0] sigma,
                                             input logic bad, input logic last);
    strip_word_t w;
    w.func   = FUNC_CAL;
    w.det    = det;
    w.chan   = chan;
    w.sample = SAMPLE_W'($urandom);
    w.base   = base;
    w.sigma  = sigma;
    w.bad    = bad;
    w.last   = last;
    return w;
  endfunction

  function automatic strip_word_t noisy_calib(input logic [DET_W-1:0] det,
                                              input logic [CHAN_W-1:0] chan);
    int                 r;
    logic [SIGMA_W-1:0] sigma;
    r = $urandom_range(19);
    if (r == 0)      sigma = '0;
    else if (r == 1) sigma = '1;
    else             sigma = SIGMA_W'($urandom_range(4, 64));
    return calib_word(det, chan, BASE_W'(16000 + $urandom_range(32)), sigma,
                      $urandom_range(15) == 0, 1'($urandom));
  endfunction

  function automatic strip_word_t sample_word(input logic [DET_W-1:0] det,
                                              input logic [SAMPLE_W-1:0] adc,
                                              input logic last);
    strip_word_t w;
    w.func   = FUNC_SAMPLE;
    w.det    = det;
    w.chan   = CHAN_W'($urandom);
    w.sample = adc;
    w.base   = BASE_W'($urandom);
    w.sigma  = SIGMA_W'($urandom);
    w.bad    = 1'($urandom);
    w.last   = last;
    return w;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_adc();
    int r;
    r = $urandom_range(49);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 12) return SAMPLE_W'(940 + $urandom_range(120));
    return SAMPLE_W'(995 + $urandom_range(10));
  endfunction

  task automatic push_word(input strip_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= w.func;
    in_ch.detector     <= w.det;
    in_ch.channel      <= w.chan;
    in_ch.sample       <= w.sample;
    in_ch.cal_baseline <= w.base;
    in_ch.cal_sigma    <= w.sigma;
    in_ch.cal_bad      <= w.bad;
    in_ch.last_sample  <= w.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_DAT_W-1:0] start,
                                input logic [CFG_DAT_W-1:0] step,
                                input logic [CFG_DAT_W-1:0] count);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_THR_START;
    cfg_data  <= start;
    @(posedge clk);
    cfg_index <= REG_THR_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= REG_THR_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic stream_frame(input int len);
    logic [DET_W-1:0]  det, d;
    logic [CHAN_W-1:0] ch;
    det = DET_W'($urandom_range(DETECTORS - 1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        ch = ($urandom_range(3) == 0) ? CHAN_W'($urandom_range(1023))
                                      : CHAN_W'($urandom_range(CHANNELS - 1));
        push_word(noisy_calib(DET_W'($urandom_range(7)), ch));
      end
      if ($urandom_range(24) == 0)
        push_word(sample_word(DET_W'($urandom_range(DETECTORS, 7)), pick_adc(),
                              1'($urandom)));
      d = ($urandom_range(9) == 0) ? DET_W'($urandom_range(DETECTORS - 1)) : det;
      push_word(sample_word(d, pick_adc(), i == len - 1));
    end
  endtask

  initial begin
    int mark, len;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_CAL;
    in_ch.detector     <= '0;
    in_ch.channel      <= '0;
    in_ch.sample       <= '0;
    in_ch.cal_baseline <= '0;
    in_ch.cal_sigma    <= '0;
    in_ch.cal_bad      <= 1'b0;
    in_ch.last_sample  <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_THR_START;
    cfg_data           <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < DETECTORS; d++)
      for (int c = 0; c < CAL_SPAN; c++)
        push_word(noisy_calib(DET_W'(d), CHAN_W'(c)));

    push_word(calib_word(3'd0, 10'd1, '1, 16'd16, 1'b0, 1'b1));
    push_word(calib_word(3'd0, 10'd2, '0, '1, 1'b0, 1'b0));
    push_word(calib_word(3'd0, 10'd3, 20'd16000, '0, 1'b0, 1'b0));
    push_word(calib_word(3'd0, 10'd4, 20'd16000, 16'd16, 1'b1, 1'b0));
    push_word(calib_word(3'd7, 10'd5, '1, '1, 1'b1, 1'b1));
    push_word(calib_word(3'd1, '1, '0, 16'd16, 1'b0, 1'b1));
    push_word(sample_word(3'd0, '0, 1'b0));
    push_word(sample_word(3'd0, '0, 1'b0));
    push_word(sample_word(3'd0, '1, 1'b0));
    push_word(sample_word(3'd5, 16'd1234, 1'b1));
    push_word(sample_word(3'd0, 16'd2000, 1'b0));
    push_word(sample_word(3'd0, 16'd2000, 1'b0));
    push_word(sample_word(3'd1, 16'd1010, 1'b0));
    push_word(sample_word(3'd0, 16'd1000, 1'b1));
    push_word(sample_word(3'd2, 16'd1003, 1'b1));
    push_word(sample_word(3'd2, '1, 1'b1));

    for (int p = 0; p < PHASES; p++) begin
      set_thresholds(START_SET[p], STEP_SET[p], COUNT_SET[p]);
      mark = random_words;
      while (random_words - mark < PHASE_WORDS) begin
        if (random_words < RANDOM_WORDS / 3) begin
          tx_idle_pct = 36;
          rx_idle_pct = 55;
        end else if (random_words < 2 * RANDOM_WORDS / 3) begin
          tx_idle_pct = 55;
          rx_idle_pct = 36;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        len = $urandom_range(1, CAL_SPAN);
        if (len > PHASE_WORDS - (random_words - mark))
          len = PHASE_WORDS - (random_words - mark);
        stream_frame(len);
        random_words += len;
      end
    end

    settle();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
design/scc_pkg.sv
design/scc_ifs.sv
design/scc_front.sv
design/scc_queue.sv
design/scc_lanes.sv
design/scc_report.sv
design/strip_cluster_count_vs_threshold.sv
sim/cluster_report_checker.sv
sim/strip_cluster_count_vs_threshold_tb.sv
